// ----- src/fkhs_pkg.sv -----
// Shared constants, codes and types of the folded key hash set.
// No dependencies; every other file of the block but fkhs_ram imports this package.
package fkhs_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HANDLE_W = 32;

  // Bucket fold: four 12-bit slices of key bits 0..47.
  localparam int unsigned SLICE_W   = 12;
  localparam int unsigned SLICE_CNT = 4;
  localparam int unsigned FOLD_W    = SLICE_W;

  // Reciprocal for the bucket modulo; exact for any fold value and divisor
  // below 2**FOLD_W + 1 when the shift is twice the fold width.
  localparam int unsigned RECIP_SHIFT = 2 * FOLD_W;
  localparam int unsigned RECIP_W     = RECIP_SHIFT;
  localparam int unsigned PROD1_W     = FOLD_W + RECIP_W;
  localparam int unsigned PROD2_W     = 2 * FOLD_W + 1;
  localparam int unsigned REM_W       = FOLD_W + 1;

  // One slot of a bucket row: handle above key.
  localparam int unsigned SLOT_W = KEY_W + HANDLE_W;

  localparam int unsigned DEF_BUCKETS = 4096;
  localparam int unsigned DEF_WAYS    = 4;

  localparam int unsigned S_FIELDS_W = CMD_W + KEY_W + HANDLE_W;
  localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_FIELDS_W = 1 + HANDLE_W + 1;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP
  } state_e;

  typedef struct packed {
    logic                dropped;
    logic [HANDLE_W-1:0] found_handle;
    logic                hit;
  } res_t;

endpackage

// ----- src/fkhs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the valid and the slot memories.
module fkhs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fkhs_bucket.sv -----
// Bucket index unit: XOR fold of the key, then modulo by reciprocal multiply.
// Depends on fkhs_pkg. Index is valid from the cycle after load_i.
module fkhs_bucket #(
  parameter int unsigned BUCKETS = fkhs_pkg::DEF_BUCKETS,
  localparam int unsigned IdxW = $clog2(BUCKETS)
) (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic [fkhs_pkg::KEY_W-1:0]  key_i,
  output logic [IdxW-1:0]             bucket_o
);
  import fkhs_pkg::*;

  localparam logic [RECIP_W-1:0] Recip =
    RECIP_W'(((2 ** RECIP_SHIFT) + BUCKETS - 1) / BUCKETS);

  logic [FOLD_W-1:0]  fold_d, fold_q;
  logic [FOLD_W-1:0]  quot_d, quot_q;
  logic [PROD1_W-1:0] prod1;
  logic [PROD2_W-1:0] prod2, diff;
  logic [REM_W-1:0]   rem, rem_fix;

  always_comb begin
    fold_d = '0;
    for (int s = 0; s < SLICE_CNT; s++) begin
      fold_d = fold_d ^ key_i[s*SLICE_W +: SLICE_W];
    end
    prod1  = PROD1_W'(fold_d) * PROD1_W'(Recip);
    quot_d = prod1[PROD1_W-1 -: FOLD_W];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fold_q <= fold_d;
      quot_q <= quot_d;
    end
  end

  // Remainder = fold - quotient * buckets, with one guard subtract.
  always_comb begin
    prod2    = PROD2_W'(quot_q) * PROD2_W'(BUCKETS);
    diff     = PROD2_W'(fold_q) - prod2;
    rem      = diff[REM_W-1:0];
    rem_fix  = (rem >= REM_W'(BUCKETS)) ? (rem - REM_W'(BUCKETS)) : rem;
    bucket_o = rem_fix[IdxW-1:0];
  end

endmodule

// ----- src/fkhs_match.sv -----
// Row compare and update: matches the key against all ways of one bucket row,
// picks the lowest free way for an insert and builds the write-back row.
// Depends on fkhs_pkg.
module fkhs_match #(
  parameter int unsigned WAYS = fkhs_pkg::DEF_WAYS,
  localparam int unsigned RowW = WAYS * fkhs_pkg::SLOT_W
) (
  input  logic [fkhs_pkg::CMD_W-1:0]    cmd_i,
  input  logic [fkhs_pkg::KEY_W-1:0]    key_i,
  input  logic [fkhs_pkg::HANDLE_W-1:0] handle_i,
  input  logic [WAYS-1:0]               vld_row_i,
  input  logic [RowW-1:0]               data_row_i,
  output fkhs_pkg::res_t                res_o,
  output logic                          row_we_o,
  output logic [WAYS-1:0]               vld_row_o,
  output logic [RowW-1:0]               data_row_o
);
  import fkhs_pkg::*;

  logic                match;
  logic [HANDLE_W-1:0] match_handle;
  logic [WAYS-1:0]     free_oh;
  logic                free_any;

  // Lowest matching way and lowest free way win.
  always_comb begin
    match        = 1'b0;
    match_handle = '0;
    free_oh      = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vld_row_i[w] && (data_row_i[w*SLOT_W +: KEY_W] == key_i)) begin
        match        = 1'b1;
        match_handle = data_row_i[w*SLOT_W + KEY_W +: HANDLE_W];
      end
      if (!vld_row_i[w]) begin
        free_oh    = '0;
        free_oh[w] = 1'b1;
      end
    end
    free_any = |free_oh;
  end

  always_comb begin
    vld_row_o = vld_row_i | free_oh;
    for (int w = 0; w < WAYS; w++) begin
      data_row_o[w*SLOT_W +: SLOT_W] = free_oh[w] ? {handle_i, key_i}
                                                 : data_row_i[w*SLOT_W +: SLOT_W];
    end
  end

  always_comb begin
    res_o    = '0;
    row_we_o = 1'b0;
    case (cmd_i)
      CMD_INSERT: begin
        res_o.hit          = match;
        res_o.found_handle = match_handle;
        if (!match) begin
          row_we_o      = free_any;
          res_o.dropped = !free_any;
        end
      end
      CMD_LOOKUP: begin
        res_o.hit          = match;
        res_o.found_handle = match_handle;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

// ----- src/folded_key_hash_set.sv -----
// Top level of the folded key hash set: sequencer, output register and the
// two bucket-row memories. Depends on fkhs_pkg, fkhs_ram, fkhs_bucket, fkhs_match.
//
//   channel  direction  tdata fields (lowest bit up)
//   s_axis   in         command[1:0], key[65:2], handle[97:66], zero pad to 104
//   m_axis   out        hit[0], found_handle[32:1], dropped[33], zero pad to 40
//
// Each request passes three steps: accept plus bucket fold, bucket-row read,
// then compare and write-back; the next request is taken only once compare is done.
// The read-modify-write of one bucket row per request keeps requests from overlapping.
// After reset, and after every clear request, the valid memory is swept one
// row a cycle; no request is accepted while the sweep runs.
// A result waiting on m_axis holds the compare stage; the input is refused
// only while a request is in flight or the sweep runs.
module folded_key_hash_set #(
  parameter int unsigned BUCKETS = fkhs_pkg::DEF_BUCKETS,
  parameter int unsigned WAYS    = fkhs_pkg::DEF_WAYS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // command, key, handle (from bit 0 up)
  input  logic [fkhs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // hit, found_handle, dropped (from bit 0 up)
  output logic [fkhs_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import fkhs_pkg::*;

  localparam int unsigned IDX_W = $clog2(BUCKETS);
  localparam int unsigned ROW_W = WAYS * SLOT_W;

  state_e state_q, state_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;

  // Request held for the whole of its processing.
  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;

  logic s_accept;
  logic out_free;
  logic rd_en;
  logic res_load;

  logic [IDX_W-1:0] bucket;

  logic             vld_we;
  logic [IDX_W-1:0] vld_waddr;
  logic [WAYS-1:0]  vld_wdata;
  logic [WAYS-1:0]  vld_rdata;
  logic             dat_we;
  logic [ROW_W-1:0] dat_rdata;

  res_t             res;
  logic             row_we;
  logic [WAYS-1:0]  vld_new;
  logic [ROW_W-1:0] dat_new;

  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q;

  assign s_accept = s_axis_tvalid & s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Capture the request on accept.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q    <= s_axis_tdata[0 +: CMD_W];
      key_q    <= s_axis_tdata[CMD_W +: KEY_W];
      handle_q <= s_axis_tdata[CMD_W + KEY_W +: HANDLE_W];
    end
  end

  // Fold and modulo; the bucket index holds until the next accept.
  fkhs_bucket #(
    .BUCKETS (BUCKETS)
  ) u_bucket (
    .clk_i    (clk_i),
    .load_i   (s_accept),
    .key_i    (s_axis_tdata[CMD_W +: KEY_W]),
    .bucket_o (bucket)
  );

  // Valid bits of one bucket row; the only memory the clear sweep touches.
  fkhs_ram #(
    .WIDTH (WAYS),
    .DEPTH (BUCKETS)
  ) u_vld_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (vld_waddr),
    .wdata_i (vld_wdata),
    .re_i    (rd_en),
    .raddr_i (bucket),
    .rdata_o (vld_rdata)
  );

  // Keys and handles of one bucket row; contents matter only where valid.
  fkhs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_dat_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (bucket),
    .wdata_i (dat_new),
    .re_i    (rd_en),
    .raddr_i (bucket),
    .rdata_o (dat_rdata)
  );

  fkhs_match #(
    .WAYS (WAYS)
  ) u_match (
    .cmd_i      (cmd_q),
    .key_i      (key_q),
    .handle_i   (handle_q),
    .vld_row_i  (vld_rdata),
    .data_row_i (dat_rdata),
    .res_o      (res),
    .row_we_o   (row_we),
    .vld_row_o  (vld_new),
    .data_row_o (dat_new)
  );

  // Next state. A clear request returns its result first, then sweeps.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == IDX_W'(BUCKETS - 1)) begin
          state_d   = ST_IDLE;
          clr_cnt_d = '0;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (out_free) begin
          state_d = (cmd_q == CMD_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Outputs of the sequencer. Reads happen only in the read state and
  // write-back only in the compare state, so a row is never read and
  // written in the same cycle.
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    res_load      = 1'b0;
    vld_we        = 1'b0;
    vld_waddr     = bucket;
    vld_wdata     = vld_new;
    dat_we        = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        vld_we    = 1'b1;
        vld_waddr = clr_cnt_q;
        vld_wdata = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
      ST_CMP: begin
        res_load = out_free;
        vld_we   = out_free & row_we;
        dat_we   = out_free & row_we;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Output register: drop the result once taken, load the next on completion.
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (res_load) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      m_data_q <= M_TDATA_W'(res);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
